// ----- rtl/spa_pkg.sv -----
`default_nettype none
package spa_pkg;

	localparam int SLOTS   = 256;
	localparam int SLOT_W  = 8;
	localparam int CNT_W   = 9;
	localparam int CFG_W   = 9;
	localparam int FUNC_W  = 2;
	localparam int WORD_W  = 32;
	localparam int WIDX_W  = 5;
	localparam int WSEL_W  = SLOT_W - WIDX_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_GET    = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

endpackage
`default_nettype wire

// ----- rtl/spa_req_if.sv -----
`default_nettype none
interface spa_req_if;
	import spa_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, output func, output slot, input ready);
	modport sink (input valid, input func, input slot, output ready);

endinterface
`default_nettype wire

// ----- rtl/spa_rsp_if.sv -----
`default_nettype none
interface spa_rsp_if;
	import spa_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic [SLOT_W-1:0] slot_index;
	logic [CNT_W-1:0]  occupied_count;

	modport source (output valid, output ok, output slot_index, output occupied_count,
		input ready);
	modport sink (input valid, input ok, input slot_index, input occupied_count,
		output ready);

endinterface
`default_nettype wire

// ----- rtl/slot_pool_allocator_top.sv -----
// Operation: remove, get and clear load the result register with the request transfer and
//   hand it on to the output register from the done state; add first scans the 32-bit
//   bitmap words from the hint (the word holding the given slot can be read twice).
// Throughput: one request at a time; the request side is not ready again until the result
//   has moved to the output register. Add runs on the single find-first-free unit walking
//   eight words, one word per cycle, and a finished result waits while the sink holds the previous one.
// Reset (arst_n low, asynchronous): every slot free, count and hint zero, capacity 256.
`default_nettype none
module slot_pool_allocator_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [spa_pkg::CFG_W-1:0] cfg_wdata,
	spa_req_if.sink                       req,
	spa_rsp_if.source                     rsp
);
	import spa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Lowest set bit of a word; zero when none is set.
	function automatic logic [WIDX_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [WIDX_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = WIDX_W'(i);
			end
		end
		return r;
	endfunction

	state_t            state_q;
	logic [SLOTS-1:0]  occ_q;          // one occupied bit per slot
	logic [CNT_W-1:0]  hint_q;         // lowest slot that may be free
	logic [CNT_W-1:0]  total_q;        // occupied slot count
	logic [CFG_W-1:0]  slots_in_use_q; // capacity register as written
	logic [CNT_W-1:0]  pos_q;          // scan position
	logic              hint_pass_q;    // 0: looking for the slot to give, 1: for the next hint
	logic              res_ok_q;
	logic [SLOT_W-1:0] res_idx_q;

	logic              rsp_valid_q;
	logic              rsp_ok_q;
	logic [SLOT_W-1:0] rsp_idx_q;
	logic [CNT_W-1:0]  rsp_cnt_q;

	// Effective capacity: the register saturates at the pool size.
	logic [CNT_W-1:0] cap;
	assign cap = (slots_in_use_q > CFG_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_in_use_q);

	logic req_xfer;
	logic rsp_free;
	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// Request decode for remove, get and clear.
	logic slot_in_cap;
	logic slot_occ;
	assign slot_in_cap = ({1'b0, req.slot} < cap);
	assign slot_occ    = slot_in_cap && occ_q[req.slot];

	// Shared find-first-free unit: one bitmap word per cycle.
	logic [WSEL_W-1:0] scan_word;
	logic              past_cap;
	logic [WORD_W-1:0] word_bits;
	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_mask;
	logic [WORD_W-1:0] free_vec;
	logic              found;
	logic [SLOT_W-1:0] found_slot;
	logic [CNT_W-1:0]  next_word_pos;
	logic              cap_in_word;

	assign scan_word   = pos_q[SLOT_W-1:WIDX_W];
	assign past_cap    = (pos_q >= cap);
	assign word_bits   = occ_q[{scan_word, {WIDX_W{1'b0}}} +: WORD_W];
	assign lo_mask     = {WORD_W{1'b1}} << pos_q[WIDX_W-1:0];
	assign cap_in_word = (cap[CNT_W-1:WIDX_W] == {1'b0, scan_word});
	assign hi_mask     = cap_in_word ? ((WORD_W'(1) << cap[WIDX_W-1:0]) - WORD_W'(1))
		: {WORD_W{1'b1}};
	assign free_vec    = ~word_bits & lo_mask & hi_mask;
	assign found       = !past_cap && (|free_vec);
	assign found_slot  = {scan_word, lowest_set(free_vec)};
	assign next_word_pos = {({1'b0, scan_word} + (WSEL_W + 1)'(1)), {WIDX_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			occ_q          <= '0;
			hint_q         <= '0;
			total_q        <= '0;
			slots_in_use_q <= CFG_W'(SLOTS);
			pos_q          <= '0;
			hint_pass_q    <= 1'b0;
			res_ok_q       <= 1'b0;
			res_idx_q      <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				slots_in_use_q <= cfg_wdata;
			end

			// Load a finished result, or drop the one the sink has taken.
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= (func_t'(req.func) == FN_ADD) ? ST_SCAN : ST_DONE;
						case (func_t'(req.func))
							FN_ADD: begin
								// Start the scan at the hint, clipped to the capacity.
								pos_q       <= (hint_q < cap) ? hint_q : cap;
								hint_pass_q <= 1'b0;
							end
							FN_REMOVE: begin
								res_idx_q <= req.slot;
								res_ok_q  <= slot_occ;
								if (slot_occ) begin
									occ_q[req.slot] <= 1'b0;
									if ({1'b0, req.slot} < hint_q) begin
										hint_q <= {1'b0, req.slot};
									end
									if (total_q != '0) begin
										total_q <= total_q - CNT_W'(1);
									end
								end
							end
							FN_GET: begin
								res_idx_q <= req.slot;
								res_ok_q  <= slot_occ;
							end
							default: begin
								// Clear frees every slot, above the capacity too.
								occ_q     <= '0;
								total_q   <= '0;
								hint_q    <= '0;
								res_idx_q <= '0;
								res_ok_q  <= 1'b1;
							end
						endcase
					end
				end

				ST_SCAN: begin
					if (found) begin
						if (!hint_pass_q) begin
							// Take the slot, then advance to find the next hint.
							occ_q[found_slot] <= 1'b1;
							total_q           <= total_q + CNT_W'(1);
							res_ok_q          <= 1'b1;
							res_idx_q         <= found_slot;
							pos_q             <= {1'b0, found_slot} + CNT_W'(1);
							hint_pass_q       <= 1'b1;
						end else begin
							hint_q  <= {1'b0, found_slot};
							state_q <= ST_DONE;
						end
					end else if (past_cap || (next_word_pos >= cap)) begin
						// Nothing free below the capacity: park the hint there.
						hint_q <= cap;
						if (!hint_pass_q) begin
							res_ok_q  <= 1'b0;
							res_idx_q <= '0;
						end
						state_q <= ST_DONE;
					end else begin
						pos_q <= next_word_pos;
					end
				end

				ST_DONE: begin
					// Hold until the output register is free.
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload register, loaded with the transfer into it.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_ok_q  <= res_ok_q;
			rsp_idx_q <= res_idx_q;
			rsp_cnt_q <= total_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = rsp_ok_q;
	assign rsp.slot_index     = rsp_idx_q;
	assign rsp.occupied_count = rsp_cnt_q;

	// The count always matches the bitmap.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == CNT_W'($countones(occ_q)))
		else $error("occupied count out of step with bitmap");

	// An accepted request always leaves idle.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> state_q != ST_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// A result is only loaded when the output register can take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready && state_q == ST_DONE) |=> state_q == ST_DONE)
		else $error("result overwrote a pending response");

endmodule
`default_nettype wire

// ----- tb/slot_pool_allocator_checker.sv -----
`default_nettype none
module slot_pool_allocator_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [spa_pkg::CFG_W-1:0] cfg_wdata,
	spa_req_if                             req,
	spa_rsp_if                             rsp,
	output int                             errors,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import spa_pkg::*;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] slot_index;
		logic [CNT_W-1:0]  occupied_count;
	} alloc_result_t;

	// Shadow of the pool
	logic             slot_taken [SLOTS];
	logic [CNT_W-1:0] next_free;
	logic [CNT_W-1:0] taken_total;
	logic [CFG_W-1:0] capacity_reg;

	alloc_result_t pending_results [$];

	initial errors = 0;

	task automatic report(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int lowest_free(int from, int lim);
		for (int i = from; i < lim; i++) begin
			if (!slot_taken[i])
				return i;
		end
		return lim;
	endfunction

	// Apply one request to the shadow pool and return what the block must answer.
	function automatic alloc_result_t alloc_outcome(func_t op, logic [SLOT_W-1:0] s);
		int lim;
		int pos;
		alloc_result_t r;
		lim = (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
		r = '0;
		case (op)
			FN_ADD: begin
				pos = lowest_free((int'(next_free) < lim) ? int'(next_free) : lim, lim);
				if (pos < lim) begin
					slot_taken[pos] = 1'b1;
					taken_total = taken_total + 1'b1;
					next_free = CNT_W'(lowest_free(pos + 1, lim));
					r.ok = 1'b1;
					r.slot_index = SLOT_W'(pos);
				end else begin
					next_free = CNT_W'(lim);
				end
			end
			FN_REMOVE: begin
				r.slot_index = s;
				if (int'(s) < lim && slot_taken[s]) begin
					slot_taken[s] = 1'b0;
					if (s < next_free)
						next_free = CNT_W'(s);
					if (taken_total != 0)
						taken_total = taken_total - 1'b1;
					r.ok = 1'b1;
				end
			end
			FN_GET: begin
				r.slot_index = s;
				r.ok = (int'(s) < lim) && slot_taken[s];
			end
			default: begin
				foreach (slot_taken[i])
					slot_taken[i] = 1'b0;
				taken_total = '0;
				next_free = '0;
				r.ok = 1'b1;
			end
		endcase
		r.occupied_count = taken_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			foreach (slot_taken[i])
				slot_taken[i] = 1'b0;
			next_free = '0;
			taken_total = '0;
			capacity_reg = CFG_W'(SLOTS);
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				capacity_reg = cfg_wdata;
			// Compare first: a result never belongs to a request of the same edge.
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					report("unexpected result, ok", rsp.ok, -1);
				end else begin
					want = pending_results.pop_front();
					if (rsp.ok !== want.ok)
						report("ok", rsp.ok, want.ok);
					if (rsp.slot_index !== want.slot_index)
						report("slot_index", rsp.slot_index, want.slot_index);
					if (rsp.occupied_count !== want.occupied_count)
						report("occupied_count", rsp.occupied_count, want.occupied_count);
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(alloc_outcome(func_t'(req.func), req.slot));
			outstanding <= pending_results.size();
		end
	end

endmodule
`default_nettype wire

// ----- tb/slot_pool_allocator_top_test.sv -----
`default_nettype none
module slot_pool_allocator_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import spa_pkg::*;

	// Quiet cycles (no transfer on either channel) before the run is declared hung.
	// The longest legitimate gap is the receiver hold-off plus an idle drain.
	localparam int QUIET_LIMIT  = 5000;
	// Cycles to let pass after the last result before touching the register;
	// covers the worst add with margin.
	localparam int SETTLE       = 24;
	localparam int IDLE_PCT     = 24;
	localparam int HOLD_AT      = 450;
	localparam int HOLD_CYCLES  = 300;
	localparam int BURST_FIRST  = 700;
	localparam int BURST_LAST   = 1000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	int errors;
	int outstanding;
	int sent;
	int settings;

	spa_req_if req_ch ();
	spa_rsp_if rsp_ch ();

	slot_pool_allocator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	slot_pool_allocator_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: end the run if the channels stay quiet for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: stall at random, never during the burst window, and once
	// hold ready low for a long stretch so the block backs up into the request side.
	initial begin
		int got;
		bit held;
		got = 0;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				got++;
			if (!held && got >= HOLD_AT) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (got >= BURST_FIRST && got < BURST_LAST)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Offer one request and wait for its transfer. Valid stays high on return so a
	// back-to-back request needs no second assignment in the same step.
	task automatic send(func_t op, int s);
		while (!(sent >= BURST_FIRST && sent < BURST_LAST) &&
				$urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= op;
		req_ch.slot  <= SLOT_W'(s);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// Drop valid, wait until every expected result is back, then let the block settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_capacity(int cap);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(cap);
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings++;
	endtask

	// Random traffic at one capacity. Slots mostly land near the live range so
	// removes and gets hit occupied entries; the rest spread over the full field.
	task automatic run_phase(int cap, int n, int add_pct, int clr_pct);
		int r;
		int hi;
		int s;
		func_t op;
		set_capacity(cap);
		hi = (cap + 1 > 255) ? 255 : cap + 1;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < add_pct)
				op = FN_ADD;
			else if (r < add_pct + clr_pct)
				op = FN_CLEAR;
			else if ($urandom_range(0, 1) == 0)
				op = FN_REMOVE;
			else
				op = FN_GET;
			if (op == FN_REMOVE || op == FN_GET)
				s = ($urandom_range(0, 9) < 8) ? $urandom_range(0, hi) : $urandom_range(0, 255);
			else
				s = $urandom_range(0, 255);
			send(op, s);
		end
	endtask

	initial begin
		// Hold every input at a known value from time zero.
		arst_n        = 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.func   <= '0;
		req_ch.slot   <= '0;
		sent = 0;
		settings = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, full capacity out of reset: free-slot get and remove, fill from
		// the bottom, remove below the hint, the top slot, and clear.
		send(FN_GET, 0);
		send(FN_REMOVE, 0);
		send(FN_ADD, 255);
		send(FN_ADD, 0);
		send(FN_ADD, 0);
		send(FN_GET, 1);
		send(FN_REMOVE, 1);
		send(FN_GET, 1);
		send(FN_ADD, 0);
		send(FN_GET, 255);
		send(FN_REMOVE, 255);
		send(FN_CLEAR, 255);
		send(FN_ADD, 0);

		// Zero capacity: everything but clear fails, even on an occupied slot.
		set_capacity(0);
		send(FN_GET, 0);
		send(FN_ADD, 0);
		send(FN_REMOVE, 0);
		send(FN_CLEAR, 0);

		// All register bits set: capacity saturates at the pool size.
		set_capacity(511);
		send(FN_ADD, 0);
		send(FN_GET, 255);

		// Capacity one: the pool is full after one add, so the next add fails.
		set_capacity(1);
		send(FN_ADD, 0);
		send(FN_GET, 0);
		send(FN_REMOVE, 0);
		send(FN_ADD, 0);
		send(FN_ADD, 0);

		// Random part. Fill the full pool, then shrink it while occupied and grow
		// it back so the hint lands on occupied slots.
		run_phase(256, 300, 70, 0);
		run_phase(256, 150, 85, 0);
		run_phase(16, 100, 40, 2);
		run_phase(256, 80, 30, 0);
		run_phase(8, 150, 45, 3);
		run_phase(37, 150, 50, 3);
		run_phase(2, 80, 45, 5);
		run_phase(300, 150, 55, 2);
		run_phase(1, 60, 45, 5);
		run_phase(0, 30, 40, 10);
		run_phase(128, 200, 60, 2);
		run_phase(511, 150, 50, 1);

		drain();
		$display("covered %0d requests over %0d capacity settings: zero, one, small, full,",
			sent, settings + 1);
		$display("  saturated, pool-full adds, shrink while occupied, and a long result stall");
		if (errors == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
